>>> hw/rtl/tape_stop_resampler_assert.svh
// ----------------------------------------------------------------------------
// Tape stop resampler assertion macros
// Concurrent assertion shorthands shared by the RTL of the block.
// ----------------------------------------------------------------------------
`ifndef TAPE_STOP_RESAMPLER_ASSERT_SVH
`define TAPE_STOP_RESAMPLER_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled during reset.
`define TSR_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("tape stop resampler: implication check failed");

// Next-cycle implication, disabled during reset.
`define TSR_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("tape stop resampler: next-cycle check failed");

`else

`define TSR_ASSERT_IMP(lbl, ck, rs, ante, cons)
`define TSR_ASSERT_NEXT(lbl, ck, rs, ante, cons)

`endif

`endif

>>> hw/rtl/tsr_pkg.sv
// ----------------------------------------------------------------------------
// Tape stop resampler package
// Shared widths, defaults, register indexes and control types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tsr_pkg;

  // Default structural parameters.
  localparam int RING_DEPTH_DEF = 16384;
  localparam int FRAC_BITS_DEF  = 16;

  // Fixed field widths.
  localparam int SAMPLE_W = 24;
  localparam int START_W  = 18;
  localparam int LEN_W    = 23;
  localparam int CFG_W    = 23;
  localparam int REG_IDX_W = 1;

  // Smoothing coefficient, 0.02 in Q0.16.
  localparam int SMOOTH_COEF = 1311;

  // Register reset values.
  localparam logic [START_W-1:0] START_SPEED_RST = START_W'(65536);
  localparam logic [LEN_W-1:0]   STOP_LENGTH_RST = LEN_W'(96000);
  localparam logic [START_W-1:0] SMOOTH_RST      = START_W'(65536);

  // Configuration register indexes.
  typedef enum logic [REG_IDX_W-1:0] {
    REG_START_SPEED = 1'b0,
    REG_STOP_LENGTH = 1'b1
  } reg_idx_t;

  // Ring memory access strobes from the sequencer.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } ring_ctl_t;

endpackage

>>> hw/rtl/tsr_ring.sv
// ----------------------------------------------------------------------------
// Tape stop ring memory
// Single-port sample ring with write pointer and fill tracking.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "tape_stop_resampler_assert.svh"

module tsr_ring #(
  parameter int RING_DEPTH = tsr_pkg::RING_DEPTH_DEF,
  parameter int IDX_W      = $clog2(RING_DEPTH)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  tsr_pkg::ring_ctl_t            ctl,
  input  logic [IDX_W-1:0]              rd_addr,
  input  logic [tsr_pkg::SAMPLE_W-1:0]  wr_data,
  output logic [tsr_pkg::SAMPLE_W-1:0]  rd_data,
  output logic [IDX_W-1:0]              wr_index,
  output logic [IDX_W-1:0]              wr_next
);
  import tsr_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);

  logic [SAMPLE_W-1:0] mem [RING_DEPTH];
  logic [SAMPLE_W-1:0] rd_q;
  logic                rd_written;
  logic                wrapped;

  // The write pointer wraps at the ring depth, not at a power of two.
  assign wr_next = (wr_index == LAST_IDX) ? '0 : wr_index + IDX_W'(1);

  // Memory array: one write or one read per cycle, read data registered.
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_index] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // Entries below the write pointer have been written until the first wrap;
  // after it every entry holds data. Unwritten entries read as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_index   <= '0;
      wrapped    <= 1'b0;
      rd_written <= 1'b0;
    end else begin
      if (ctl.wr_en) begin
        wr_index <= wr_next;
        if (wr_index == LAST_IDX) begin
          wrapped <= 1'b1;
        end
      end
      if (ctl.rd_en) begin
        rd_written <= wrapped || (rd_addr < wr_index);
      end
    end
  end

  assign rd_data = rd_written ? rd_q : '0;

  // The sequencer never reads and writes in the same cycle.
  `TSR_ASSERT_IMP(a_ring_rw_excl, clk, rst, ctl.rd_en, !ctl.wr_en)
  `TSR_ASSERT_IMP(a_ring_wr_range, clk, rst, 1'b1, wr_index <= LAST_IDX)
  `TSR_ASSERT_NEXT(a_ring_wrap_sticky, clk, rst, wrapped, wrapped)

endmodule

>>> hw/rtl/tsr_div.sv
// ----------------------------------------------------------------------------
// Tape stop deceleration divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tsr_div #(
  parameter int DIVIDEND_W = tsr_pkg::START_W + tsr_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [DIVIDEND_W-1:0]      dividend,
  input  logic [tsr_pkg::LEN_W-1:0]  divisor,
  output logic                       done,
  output logic [DIVIDEND_W-1:0]      quotient
);
  import tsr_pkg::*;

  localparam int CNT_W = $clog2(DIVIDEND_W);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(DIVIDEND_W - 1);

  logic                 busy;
  logic [CNT_W-1:0]     count;
  logic [LEN_W-1:0]     rem;
  logic [LEN_W-1:0]     dsr;
  logic [LEN_W:0]       trial;
  logic                 fits;

  // Shift the next dividend bit into the partial remainder and try it.
  assign trial = {rem, quotient[DIVIDEND_W-1]};
  assign fits  = trial >= {1'b0, dsr};

  // The quotient register starts as the dividend and fills from the right.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        count    <= '0;
        rem      <= '0;
        dsr      <= divisor;
        quotient <= dividend;
      end else if (busy) begin
        rem      <= fits ? LEN_W'(trial - {1'b0, dsr}) : trial[LEN_W-1:0];
        quotient <= {quotient[DIVIDEND_W-2:0], fits};
        count    <= count + CNT_W'(1);
        if (count == LAST_CNT) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> hw/rtl/tape_stop_resampler.sv
// ----------------------------------------------------------------------------
// Tape stop resampler
// Ring-buffered audio path that slows playback to a stop with linear
// interpolation, or passes samples through while disabled.
// ----------------------------------------------------------------------------
//  Channel   Signals                                   Direction
//  input     in_valid, in_ready, sample_in, enable,
//            buffer_start                              into the block
//  output    out_valid, out_ready, sample_out, stopping out of the block
//  config    cfg_write, cfg_index, cfg_data            into the block
//
//  A passthrough beat steps through S_SPD and S_OUT; an interpolated beat
//  adds S_RD1, S_RD2, S_MUL and S_FIN for the two single-port reads of the
//  ring memory and the interpolation multiply. A buffer start adds S_BUF,
//  an enabled one S_DCHK for the divide check, and S_DIV while the
//  deceleration is recomputed by the one-bit-per-cycle divider.
//  One beat is in flight at a time; the next input beat is taken while the
//  finished result waits in the output register.
//  Reset is synchronous; the ring reads as zero until entries are written,
//  so no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "tape_stop_resampler_assert.svh"

module tape_stop_resampler #(
  parameter int RING_DEPTH = tsr_pkg::RING_DEPTH_DEF,
  parameter int FRAC_BITS  = tsr_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [tsr_pkg::SAMPLE_W-1:0] sample_in,
  input  logic                                enable,
  input  logic                                buffer_start,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [tsr_pkg::SAMPLE_W-1:0] sample_out,
  output logic                                stopping,
  input  logic                                cfg_write,
  input  logic [tsr_pkg::REG_IDX_W-1:0]       cfg_index,
  input  logic [tsr_pkg::CFG_W-1:0]           cfg_data
);
  import tsr_pkg::*;

  localparam int IDX_W  = $clog2(RING_DEPTH);
  localparam int POS_W  = IDX_W + FRAC_BITS;
  localparam int SPD_W  = START_W + FRAC_BITS;
  localparam int PROD_W = SAMPLE_W + 2 + FRAC_BITS;

  localparam logic [SPD_W-1:0] SPEED_ONE = SPD_W'(64'd1 << (FRAC_BITS + 16));
  localparam logic [SPD_W-1:0] SPEED_FLOOR =
    SPD_W'(((64'd1 << (FRAC_BITS + 16)) + 64'd50) / 64'd100);
  localparam logic [POS_W:0] POS_LIMIT = (POS_W + 1)'(RING_DEPTH) << FRAC_BITS;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);
  localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) << (FRAC_BITS - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_BUF, S_DCHK, S_DIV, S_SPD, S_RD1, S_RD2, S_MUL, S_FIN, S_OUT
  } state_t;

  state_t state;

  // Configuration and tape state.
  logic [START_W-1:0] start_speed;
  logic [LEN_W-1:0]   stop_length;
  logic [START_W-1:0] smoothed_speed;
  logic [SPD_W-1:0]   cur_speed;
  logic [SPD_W-1:0]   decel_step;
  logic [POS_W-1:0]   read_pos;
  logic               stop_active;
  logic               enable_held;

  // Per-beat working registers.
  logic signed [SAMPLE_W-1:0] sample_r;
  logic                       en_r;
  logic                       bs_r;
  logic [IDX_W-1:0]           rd_idx1;
  logic [FRAC_BITS-1:0]       frac_r;
  logic signed [SAMPLE_W-1:0] s1;
  logic signed [SAMPLE_W-1:0] s2;
  logic signed [PROD_W-1:0]   prod;
  logic signed [SAMPLE_W-1:0] res;

  // Ring and divider connections.
  ring_ctl_t           ring_ctl;
  logic [IDX_W-1:0]    ring_rd_addr;
  logic [SAMPLE_W-1:0] ring_rd_data;
  logic [IDX_W-1:0]    wr_index;
  logic [IDX_W-1:0]    wr_next;
  logic                div_start;
  logic                div_done;
  logic [SPD_W-1:0]    div_quot;

  // Combinational helpers.
  logic signed [START_W:0]  sm_delta;
  logic signed [31:0]       sm_prod;
  logic signed [31:0]       sm_sum;
  logic [START_W-1:0]       sm_next;
  logic [SPD_W-1:0]         spd_dec;
  logic [SPD_W-1:0]         spd_clamp;
  logic [IDX_W-1:0]         rd_idx0;
  logic [POS_W:0]           pos_sum;
  logic [POS_W:0]           pos_wrap;
  logic signed [SAMPLE_W:0] diff;
  logic signed [PROD_W-1:0] interp;
  logic                     div_needed;
  logic                     out_load;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      start_speed <= START_SPEED_RST;
      stop_length <= STOP_LENGTH_RST;
    end else if (cfg_write) begin
      unique case (reg_idx_t'(cfg_index))
        REG_START_SPEED: start_speed <= cfg_data[START_W-1:0];
        REG_STOP_LENGTH: stop_length <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // One smoothing step toward the start speed, rounded to nearest.
  always_comb begin
    sm_delta = $signed({1'b0, start_speed}) - $signed({1'b0, smoothed_speed});
    sm_prod  = 32'(sm_delta) * 32'sd1311 + 32'sd32768;
    sm_sum   = $signed({14'd0, smoothed_speed}) + (sm_prod >>> 16);
    sm_next  = sm_sum[START_W-1:0];
  end

  // Per-sample deceleration with the floor clamp.
  assign spd_dec   = (cur_speed > decel_step) ? cur_speed - decel_step : '0;
  assign spd_clamp = (spd_dec < SPEED_FLOOR) ? SPEED_FLOOR : spd_dec;

  // Read position advance by the truncated speed, wrapping at the ring size.
  assign rd_idx0  = read_pos[POS_W-1:FRAC_BITS];
  assign pos_sum  = {1'b0, read_pos} + (POS_W + 1)'(cur_speed[SPD_W-1:16]);
  assign pos_wrap = (pos_sum >= POS_LIMIT) ? pos_sum - POS_LIMIT : pos_sum;

  // Interpolation: difference, then rounding of the registered product.
  assign diff   = (SAMPLE_W + 1)'(s2) - (SAMPLE_W + 1)'(s1);
  assign interp = ((prod + HALF) >>> FRAC_BITS) + PROD_W'(s1);

  assign div_needed = (stop_length != '0) && (cur_speed > SPEED_FLOOR);
  assign div_start  = (state == S_DCHK) && div_needed;
  assign out_load   = (state == S_OUT) && (!out_valid || out_ready);
  assign in_ready   = (state == S_IDLE);

  // Ring accesses: two reads for an interpolated beat, then one write; a passthrough beat only writes.
  always_comb begin
    ring_ctl.rd_en = ((state == S_SPD) && enable_held) || (state == S_RD1);
    ring_ctl.wr_en = ((state == S_SPD) && !enable_held) || (state == S_RD2);
    ring_rd_addr   = (state == S_RD1) ? rd_idx1 : rd_idx0;
  end

  // Sequencer and all tape state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      smoothed_speed <= SMOOTH_RST;
      cur_speed      <= SPEED_ONE;
      decel_step     <= '0;
      read_pos       <= '0;
      stop_active    <= 1'b0;
      enable_held    <= 1'b0;
      out_valid      <= 1'b0;
      stopping       <= 1'b0;
    end else begin
      if (out_valid && out_ready && !out_load) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            sample_r <= sample_in;
            en_r     <= enable;
            bs_r     <= buffer_start;
            state    <= buffer_start ? S_BUF : S_SPD;
          end
        end
        S_BUF: begin
          enable_held    <= en_r;
          smoothed_speed <= sm_next;
          if (en_r) begin
            if (!stop_active) begin
              stop_active <= 1'b1;
              cur_speed   <= {sm_next, {FRAC_BITS{1'b0}}};
            end
            state <= S_DCHK;
          end else begin
            state <= S_SPD;
          end
        end
        S_DCHK: begin
          if (div_needed) begin
            state <= S_DIV;
          end else begin
            decel_step <= '0;
            state      <= S_SPD;
          end
        end
        S_DIV: begin
          if (div_done) begin
            decel_step <= div_quot;
            state      <= S_SPD;
          end
        end
        S_SPD: begin
          if (enable_held) begin
            cur_speed <= spd_clamp;
            rd_idx1   <= (rd_idx0 == LAST_IDX) ? '0 : rd_idx0 + IDX_W'(1);
            frac_r    <= read_pos[FRAC_BITS-1:0];
            state     <= S_RD1;
          end else begin
            res         <= sample_r;
            stop_active <= 1'b0;
            cur_speed   <= SPEED_ONE;
            read_pos    <= {wr_next, {FRAC_BITS{1'b0}}};
            state       <= S_OUT;
          end
        end
        S_RD1: begin
          s1       <= $signed(ring_rd_data);
          read_pos <= pos_wrap[POS_W-1:0];
          state    <= S_RD2;
        end
        S_RD2: begin
          s2    <= $signed(ring_rd_data);
          state <= S_MUL;
        end
        S_MUL: begin
          prod  <= PROD_W'(diff) * PROD_W'($signed({1'b0, frac_r}));
          state <= S_FIN;
        end
        S_FIN: begin
          res   <= interp[SAMPLE_W-1:0];
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            sample_out <= res;
            stopping   <= enable_held;
            out_valid  <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Sample ring.
  tsr_ring #(
    .RING_DEPTH (RING_DEPTH),
    .IDX_W      (IDX_W)
  ) u_ring (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ring_ctl),
    .rd_addr  (ring_rd_addr),
    .wr_data  (sample_r),
    .rd_data  (ring_rd_data),
    .wr_index (wr_index),
    .wr_next  (wr_next)
  );

  // Deceleration step divider: (speed - floor) / stop length.
  tsr_div #(
    .DIVIDEND_W (SPD_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (cur_speed - SPEED_FLOOR),
    .divisor  (stop_length),
    .done     (div_done),
    .quotient (div_quot)
  );

  `TSR_ASSERT_IMP(a_pos_range, clk, rst, 1'b1, {1'b0, read_pos} < POS_LIMIT)
  `TSR_ASSERT_IMP(a_speed_floor, clk, rst, state == S_RD1, cur_speed >= SPEED_FLOOR)
  `TSR_ASSERT_IMP(a_off_clears_stop, clk, rst, (state == S_OUT) && !enable_held, !stop_active)
  `TSR_ASSERT_NEXT(a_bs_updates, clk, rst, (state == S_BUF) && en_r, stop_active && bs_r)

endmodule
